// ----- hdl/sgvc_pkg.sv -----
// Shared widths, codes and types of the scan geometry vote classifier.
package sgvc_pkg;

  localparam int ANGLE_W  = 20;
  localparam int COUNT_W  = 12;
  localparam int RANGE_W  = 16;
  localparam int STAMP_W  = 63;
  localparam int SRC_W    = 8;
  localparam int WIN_W    = 10;
  localparam int THR_W    = 19;
  localparam int DECL_W   = ANGLE_W + 1;
  localparam int IDX_W    = 32;
  localparam int CLASS_W  = 2;
  localparam int VERD_W   = 2;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 19;

  localparam int MAX_SCAN_POINTS = 4096;

  localparam logic [CLASS_W-1:0] CLS_FULL      = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_PARTIAL   = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_MALFORMED = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN   = 2'd3;

  localparam logic [VERD_W-1:0] VERD_UNKNOWN = 2'd0;
  localparam logic [VERD_W-1:0] VERD_FULL    = 2'd1;
  localparam logic [VERD_W-1:0] VERD_PARTIAL = 2'd2;

  localparam logic [MODE_W-1:0] MODE_CLASSIFYING = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FULL        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PARTIAL     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUP_SOURCE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 4'd1;

  typedef struct packed {
    logic              meta_ok;
    logic [DECL_W-1:0] declared;
    logic [IDX_W-1:0]  indexed;
  } sgvc_geom_t;

endpackage

// ----- hdl/sgvc_if.sv -----
// Channel interfaces: scan metadata in, classification out, register writes.
interface sgvc_in_if;
  import sgvc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ANGLE_W-1:0]  start_angle;
  logic signed [ANGLE_W-1:0]  end_angle;
  logic signed [ANGLE_W-1:0]  angle_step;
  logic [COUNT_W-1:0]         point_count;
  logic [RANGE_W-1:0]         range_lower;
  logic [RANGE_W-1:0]         range_upper;
  logic                       fields_finite;
  logic [STAMP_W-1:0]         stamp_ns;
  logic [SRC_W-1:0]           source_count;

  modport source (output valid, start_angle, end_angle, angle_step, point_count, range_lower,
                  range_upper, fields_finite, stamp_ns, source_count, input ready);
  modport sink (input valid, start_angle, end_angle, angle_step, point_count, range_lower,
                range_upper, fields_finite, stamp_ns, source_count, output ready);
endinterface

interface sgvc_out_if;
  import sgvc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] scan_class;
  logic               stamp_rising;
  logic               verdict_locked;
  logic [VERD_W-1:0]  stream_verdict;
  logic [MODE_W-1:0]  audit_mode;
  logic               stream_ready;

  modport source (output valid, scan_class, stamp_rising, verdict_locked, stream_verdict,
                  audit_mode, stream_ready, input ready);
  modport sink (input valid, scan_class, stamp_rising, verdict_locked, stream_verdict,
                audit_mode, stream_ready, output ready);
endinterface

interface sgvc_cfg_if;
  import sgvc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- hdl/sgvc_front.sv -----
// Scan geometry front end: metadata checks, declared span and indexed span.
module sgvc_front #(
  parameter int MAX_POINTS = sgvc_pkg::MAX_SCAN_POINTS
) (
  input  logic signed [sgvc_pkg::ANGLE_W-1:0] start_angle,
  input  logic signed [sgvc_pkg::ANGLE_W-1:0] end_angle,
  input  logic signed [sgvc_pkg::ANGLE_W-1:0] angle_step,
  input  logic [sgvc_pkg::COUNT_W-1:0]        point_count,
  input  logic [sgvc_pkg::RANGE_W-1:0]        range_lower,
  input  logic [sgvc_pkg::RANGE_W-1:0]        range_upper,
  input  logic                                fields_finite,
  output sgvc_pkg::sgvc_geom_t                geom
);
  import sgvc_pkg::*;

  localparam int CNT_CMP_W = 17;

  logic signed [DECL_W-1:0] diff;
  logic [ANGLE_W-1:0]       step_mag;
  logic [COUNT_W-1:0]       cnt_m1;

  always_comb begin
    diff     = DECL_W'(end_angle) - DECL_W'(start_angle);
    step_mag = angle_step[ANGLE_W-1] ? ANGLE_W'(-angle_step) : ANGLE_W'(angle_step);
    cnt_m1   = point_count - COUNT_W'(1);

    geom.declared = diff[DECL_W-1] ? DECL_W'(-diff) : DECL_W'(diff);
    geom.indexed  = IDX_W'(step_mag) * IDX_W'(cnt_m1);
    geom.meta_ok  = (point_count != '0) &&
                    (CNT_CMP_W'(point_count) <= CNT_CMP_W'(MAX_POINTS)) &&
                    fields_finite && (angle_step != '0) &&
                    (range_upper >= range_lower);
  end

endmodule

// ----- hdl/scan_geometry_vote_classifier_core.sv -----
// Scan geometry vote classifier top level: input stage, classify and vote, result register.
//
//  channel | dir | handshake    | word
//  in_s    | in  | valid/ready  | start_angle, end_angle, angle_step, point_count, range_lower,
//          |     |              | range_upper, fields_finite, stamp_ns, source_count
//  out_s   | out | valid/ready  | scan_class, stamp_rising, verdict_locked, stream_verdict,
//          |     |              | audit_mode, stream_ready
//  cfg_s   | in  | valid/ready  | reg_index, wdata (0 window_messages, 1 full_span_threshold)
//
// One word per cycle while out_s is ready; a taken word passes both stage registers.
// Span multiply sits before the input stage register; stamp compare, class and vote sit
// before the result register, which also updates the vote state.
// Synchronous active-low reset clears valids, vote state and restores register defaults.
// A stalled out_s holds the result; in_s keeps taking words until both stages are full.
module scan_geometry_vote_classifier_core #(
  parameter int MAX_POINTS = sgvc_pkg::MAX_SCAN_POINTS
) (
  input  logic       clk,
  input  logic       rst_n,
  sgvc_in_if.sink    in_s,
  sgvc_out_if.source out_s,
  sgvc_cfg_if.sink   cfg_s
);
  import sgvc_pkg::*;

  localparam int MUL10_W = IDX_W + 4;
  localparam int VOTE_W  = WIN_W + 5;

  logic [WIN_W-1:0]   window_r;
  logic [THR_W-1:0]   thresh_r;

  logic               s1_vld_r;
  sgvc_geom_t         s1_geom_r;
  logic [STAMP_W-1:0] s1_stamp_r;
  logic [SRC_W-1:0]   s1_src_r;
  sgvc_geom_t         geom;

  logic [STAMP_W-1:0] last_stamp_r;
  logic               stamp_seen_r;
  logic               locked_r;
  logic [WIN_W-1:0]   sample_r;
  logic [WIN_W-1:0]   full_r;
  logic [WIN_W-1:0]   part_r;
  logic [WIN_W-1:0]   malf_r;
  logic [VERD_W-1:0]  verdict_r;
  logic [MODE_W-1:0]  mode_r;

  logic               locked_nxt;
  logic [WIN_W-1:0]   sample_nxt;
  logic [WIN_W-1:0]   full_nxt;
  logic [WIN_W-1:0]   part_nxt;
  logic [WIN_W-1:0]   malf_nxt;
  logic [VERD_W-1:0]  verdict_nxt;
  logic [MODE_W-1:0]  mode_nxt;

  logic               out_vld_r;
  logic [CLASS_W-1:0] cls_r;
  logic               rising_r;
  logic               locked_out_r;
  logic [VERD_W-1:0]  verdict_out_r;
  logic [MODE_W-1:0]  mode_out_r;
  logic               sready_r;

  logic               advance;
  logic               rising;
  logic [CLASS_W-1:0] cls;
  logic               full_idx;
  logic               full_meta;
  logic [MUL10_W-1:0] ind_x10;
  logic [MUL10_W-1:0] dec_x9;
  logic [WIN_W:0]     classified;
  logic [VOTE_W-1:0]  full_x10;
  logic [VOTE_W-1:0]  part_x10;
  logic [VOTE_W-1:0]  class_x9;
  logic               vote_ok;

  sgvc_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .start_angle   (in_s.start_angle),
    .end_angle     (in_s.end_angle),
    .angle_step    (in_s.angle_step),
    .point_count   (in_s.point_count),
    .range_lower   (in_s.range_lower),
    .range_upper   (in_s.range_upper),
    .fields_finite (in_s.fields_finite),
    .geom          (geom)
  );

  assign advance     = s1_vld_r && (!out_vld_r || out_s.ready);
  assign in_s.ready  = !s1_vld_r || advance;
  assign cfg_s.ready = 1'b1;

  always_comb begin
    rising = (s1_stamp_r != '0) && (!stamp_seen_r || (s1_stamp_r > last_stamp_r));

    ind_x10  = (MUL10_W'(s1_geom_r.indexed) << 3) + (MUL10_W'(s1_geom_r.indexed) << 1);
    dec_x9   = (MUL10_W'(s1_geom_r.declared) << 3) + MUL10_W'(s1_geom_r.declared);
    full_idx = s1_geom_r.indexed >= IDX_W'(thresh_r);
    full_meta = (s1_geom_r.declared >= DECL_W'(thresh_r)) && (ind_x10 >= dec_x9);

    if (!s1_geom_r.meta_ok || !rising) begin
      cls = CLS_MALFORMED;
    end else if (s1_geom_r.indexed == '0) begin
      cls = CLS_UNKNOWN;
    end else if (full_idx || full_meta) begin
      cls = CLS_FULL;
    end else begin
      cls = CLS_PARTIAL;
    end

    locked_nxt  = locked_r;
    sample_nxt  = sample_r;
    full_nxt    = full_r;
    part_nxt    = part_r;
    malf_nxt    = malf_r;
    verdict_nxt = verdict_r;
    mode_nxt    = mode_r;
    classified  = '0;
    full_x10    = '0;
    part_x10    = '0;
    class_x9    = '0;
    vote_ok     = 1'b0;

    if (!locked_r) begin
      if (sample_r != '1) begin
        sample_nxt = sample_r + WIN_W'(1);
      end
      case (cls)
        CLS_FULL:      full_nxt = full_r + WIN_W'(1);
        CLS_PARTIAL:   part_nxt = part_r + WIN_W'(1);
        CLS_MALFORMED: malf_nxt = malf_r + WIN_W'(1);
        default: ;
      endcase

      classified = (WIN_W+1)'(full_nxt) + (WIN_W+1)'(part_nxt);
      full_x10   = (VOTE_W'(full_nxt) << 3) + (VOTE_W'(full_nxt) << 1);
      part_x10   = (VOTE_W'(part_nxt) << 3) + (VOTE_W'(part_nxt) << 1);
      class_x9   = (VOTE_W'(classified) << 3) + VOTE_W'(classified);
      vote_ok    = (classified != '0) && (malf_nxt == '0);

      if (sample_nxt >= window_r) begin
        if (vote_ok && (full_x10 >= class_x9)) begin
          verdict_nxt = VERD_FULL;
          mode_nxt    = MODE_FULL;
        end else if (vote_ok && (part_x10 >= class_x9)) begin
          verdict_nxt = VERD_PARTIAL;
          mode_nxt    = MODE_PARTIAL;
        end else begin
          verdict_nxt = VERD_UNKNOWN;
          mode_nxt    = MODE_UNKNOWN;
        end
        locked_nxt = 1'b1;
      end
    end

    if (s1_src_r != SRC_W'(1)) begin
      mode_nxt = MODE_DUP_SOURCE;
    end else if (!locked_nxt) begin
      mode_nxt = MODE_CLASSIFYING;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_W'(20);
      thresh_r <= THR_W'(380109);
    end else if (cfg_s.valid) begin
      case (cfg_s.reg_index)
        CFG_WINDOW: window_r <= cfg_s.wdata[WIN_W-1:0];
        CFG_THRESH: thresh_r <= cfg_s.wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_vld_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      s1_geom_r  <= geom;
      s1_stamp_r <= in_s.stamp_ns;
      s1_src_r   <= in_s.source_count;
    end
  end

  // vote state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      stamp_seen_r <= 1'b0;
      locked_r     <= 1'b0;
      sample_r     <= '0;
      full_r       <= '0;
      part_r       <= '0;
      malf_r       <= '0;
      verdict_r    <= VERD_UNKNOWN;
      mode_r       <= MODE_CLASSIFYING;
    end else if (advance) begin
      if (rising) begin
        last_stamp_r <= s1_stamp_r;
        stamp_seen_r <= 1'b1;
      end
      locked_r  <= locked_nxt;
      sample_r  <= sample_nxt;
      full_r    <= full_nxt;
      part_r    <= part_nxt;
      malf_r    <= malf_nxt;
      verdict_r <= verdict_nxt;
      mode_r    <= mode_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_s.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cls_r         <= cls;
      rising_r      <= rising;
      locked_out_r  <= locked_nxt;
      verdict_out_r <= verdict_nxt;
      mode_out_r    <= mode_nxt;
      sready_r      <= locked_nxt && (verdict_nxt != VERD_UNKNOWN) && (s1_src_r == SRC_W'(1));
    end
  end

  assign out_s.valid          = out_vld_r;
  assign out_s.scan_class     = cls_r;
  assign out_s.stamp_rising   = rising_r;
  assign out_s.verdict_locked = locked_out_r;
  assign out_s.stream_verdict = verdict_out_r;
  assign out_s.audit_mode     = mode_out_r;
  assign out_s.stream_ready   = sready_r;

endmodule

// ----- hdl/sgvc_checker.sv -----
// Port-level checks of the classifier result stream, bound to the top level.
module sgvc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sgvc_pkg::CLASS_W-1:0] scan_class,
  input logic                         stamp_rising,
  input logic                         verdict_locked,
  input logic [sgvc_pkg::VERD_W-1:0]  stream_verdict,
  input logic [sgvc_pkg::MODE_W-1:0]  audit_mode,
  input logic                         stream_ready
);
  import sgvc_pkg::*;

  logic locked_seen_r;
  logic out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_seen_r <= 1'b0;
    end else if (out_acc && verdict_locked) begin
      locked_seen_r <= 1'b1;
    end
  end

  // lock is sticky across words
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && locked_seen_r |-> verdict_locked)
    else $error("verdict lock dropped");

  a_unlocked_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !verdict_locked |-> stream_verdict == VERD_UNKNOWN &&
      (audit_mode == MODE_CLASSIFYING || audit_mode == MODE_DUP_SOURCE))
    else $error("verdict or audit mode set before lock");

  // duplicate publisher mode can still be set after lock; it also gates stream ready
  a_ready_needs_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && stream_ready |-> verdict_locked && stream_verdict != VERD_UNKNOWN)
    else $error("stream ready without a usable verdict");

  a_class_needs_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && scan_class != CLS_MALFORMED |-> stamp_rising)
    else $error("classified scan without a rising stamp");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({scan_class, stamp_rising, verdict_locked, stream_verdict, audit_mode,
               stream_ready}))
    else $error("stalled result word changed");

endmodule

bind scan_geometry_vote_classifier_core sgvc_checker u_sgvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .scan_class     (out_s.scan_class),
  .stamp_rising   (out_s.stamp_rising),
  .verdict_locked (out_s.verdict_locked),
  .stream_verdict (out_s.stream_verdict),
  .audit_mode     (out_s.audit_mode),
  .stream_ready   (out_s.stream_ready)
);
